// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key differencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, switched off while reset is held
`define KRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked implication that checks the following cycle
`define KRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/krd_pkg.sv =====
// ----------------------------------------------------------------------------
// krd_pkg
// Constants shared by the keyboard report key differencer and its checker.
// ----------------------------------------------------------------------------
package krd_pkg;

  // Key slots carried by the input beat
  localparam int IN_SLOTS          = 6;
  // Default number of stored key slots
  localparam int KEY_SLOTS_DEF     = 6;

  localparam int USAGE_W           = 8;
  localparam int MODS_W            = 8;
  localparam int LEN_W             = 7;

  // Usages up to and including this one never raise an event
  localparam logic [USAGE_W-1:0] USAGE_RESERVED_MAX = 8'd3;
  // Reports shorter than this are dropped
  localparam logic [LEN_W-1:0]   MIN_REPORT_BYTES   = 7'd8;

  localparam int IN_TDATA_W        = 64;
  localparam int OUT_TDATA_W       = 16;

endpackage

// ===== hdl/keyboard_report_key_diff_unit.sv =====
// The first event of a report is loaded into the single event output register from the
// pending mask and payload registers captured with its beat. Throughput: one event beat
// per cycle while out_tready is high; a report gives at most 2*KEY_SLOTS events. The next
// report is taken in the cycle its predecessor's last event is loaded.
// Reset (rst_n low, synchronous) clears the stored slots, stored modifiers and pending events.
// ----------------------------------------------------------------------------
// keyboard_report_key_diff_unit
// Compares each boot keyboard report with the previous one and streams out
// key release and key press events, releases first, each in slot order.
// ----------------------------------------------------------------------------
module keyboard_report_key_diff_unit
  import krd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // report_length[6:0], modifier_bits[14:7], slot_zero[22:15], slot_one[30:23],
  // slot_two[38:31], slot_three[46:39], slot_four[54:47], slot_five[62:55], pad[63]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // key_usage[7:0], event_modifiers[15:8]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // is_press[0]
  output logic                   out_tuser,
  // last_event
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  // Event mask: low half releases, high half presses
  localparam int EV_W = 2 * KEY_SLOTS;

  // Stored report
  logic [USAGE_W-1:0] prev_slots_r [KEY_SLOTS];
  logic [MODS_W-1:0]  prev_mods_r;

  // Pending events of the report in flight
  logic [EV_W-1:0]    pend_r, pend_nxt;
  logic [USAGE_W-1:0] ev_usage_r [EV_W];
  logic [MODS_W-1:0]  rel_mods_r;
  logic [MODS_W-1:0]  press_mods_r;

  // Output register
  logic [USAGE_W-1:0] out_usage_r;
  logic [MODS_W-1:0]  out_mods_r;
  logic               out_press_r;
  logic               out_last_r;
  logic               out_valid_r;

  // Incoming beat, unpacked
  logic [LEN_W-1:0]   in_len;
  logic [MODS_W-1:0]  in_mods;
  logic [USAGE_W-1:0] cur_slots [KEY_SLOTS];
  logic               in_fire;
  logic               rpt_ok;

  logic [KEY_SLOTS-1:0] rel_hit;
  logic [KEY_SLOTS-1:0] press_hit;

  logic               out_load;
  logic [EV_W-1:0]    pick;
  logic [EV_W-1:0]    pend_left;
  logic [USAGE_W-1:0] sel_usage;
  logic               sel_press;

  assign in_len  = in_tdata[LEN_W-1:0];
  assign in_mods = in_tdata[LEN_W +: MODS_W];

  // Slots beyond the beat read as empty; extra beat slots are dropped
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cur
    if (g < IN_SLOTS) begin : g_in
      assign cur_slots[g] = in_tdata[LEN_W + MODS_W + g*USAGE_W +: USAGE_W];
    end else begin : g_zero
      assign cur_slots[g] = '0;
    end
  end

  // Release: stored usage gone from the new report. Press: new usage not held before.
  always_comb begin
    logic rel_seen;
    logic press_seen;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      rel_seen   = 1'b0;
      press_seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        rel_seen   = rel_seen   | (prev_slots_r[i] == cur_slots[j]);
        press_seen = press_seen | (cur_slots[i] == prev_slots_r[j]);
      end
      rel_hit[i]   = (prev_slots_r[i] > USAGE_RESERVED_MAX) && !rel_seen;
      press_hit[i] = (cur_slots[i] > USAGE_RESERVED_MAX) && !press_seen;
    end
  end

  // Load the output register when an event is pending and it is empty or being drained
  assign out_load  = (pend_r != '0) && (!out_valid_r || out_tready);
  // Lowest pending event goes first
  assign pick      = out_load ? (pend_r & (~pend_r + EV_W'(1))) : '0;
  assign pend_left = pend_r & ~pick;

  always_comb begin
    sel_usage = '0;
    for (int k = 0; k < EV_W; k++) begin
      sel_usage = sel_usage | (ev_usage_r[k] & {USAGE_W{pick[k]}});
    end
    sel_press = |pick[EV_W-1:KEY_SLOTS];
  end

  // Take a new report once the last pending event has left for the output register
  assign in_tready = (pend_left == '0);
  assign in_fire   = in_tvalid && in_tready;
  assign rpt_ok    = (in_len >= MIN_REPORT_BYTES);

  always_comb begin
    pend_nxt = pend_left;
    if (in_fire && rpt_ok) begin
      pend_nxt = {press_hit, rel_hit};
    end
  end

  // Control state and stored report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      prev_mods_r <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_slots_r[i] <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && rpt_ok) begin
        prev_mods_r <= in_mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          prev_slots_r[i] <= cur_slots[i];
        end
      end
    end
  end

  // Event payload: capture usages and modifier tags of the accepted report
  always_ff @(posedge clk) begin
    if (in_fire && rpt_ok) begin
      rel_mods_r   <= prev_mods_r;
      press_mods_r <= in_mods;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        ev_usage_r[i]             <= prev_slots_r[i];
        ev_usage_r[KEY_SLOTS + i] <= cur_slots[i];
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_usage_r <= sel_usage;
      out_mods_r  <= sel_press ? press_mods_r : rel_mods_r;
      out_press_r <= sel_press;
      out_last_r  <= (pend_left == '0);
    end
  end

  assign out_tdata  = {out_mods_r, out_usage_r};
  assign out_tuser  = out_press_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/krd_checker.sv =====
// ----------------------------------------------------------------------------
// krd_checker
// Port-level checks for the keyboard report key differencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module krd_checker
  import krd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // Reserved usages never leave as events
  `KRD_ASSERT_IMPL(a_usage_valid, clk, rst_n, out_tvalid, out_tdata[USAGE_W-1:0] > USAGE_RESERVED_MAX, "event carries reserved usage")

  // Input held back only while events are queued, so a beat must be on show next
  `KRD_ASSERT_NEXT(a_stall_has_event, clk, rst_n, !in_tready, out_tvalid, "input stalled with no event to deliver")

  // Stalled beat holds
  `KRD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "output beat dropped under stall")

  `KRD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output beat changed under stall")

endmodule

bind keyboard_report_key_diff_unit krd_checker u_krd_checker (.*);

// ===== sim/keyboard_report_key_diff_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_key_diff_unit_test
// Self-checking bench for the key report differencer: streams boot keyboard
// reports in bursts, keeps its own copy of the held keys and modifiers, and
// checks every release and press beat against its own prediction.
// ----------------------------------------------------------------------------
module keyboard_report_key_diff_unit_test;
  import krd_pkg::*;

  // One input beat, laid out exactly as in_tdata: length in the lowest bits,
  // then the modifier byte, then slot 0 up to slot 5, pad bit on top.
  typedef struct packed {
    logic                              pad;
    logic [IN_SLOTS-1:0][USAGE_W-1:0]  slots;
    logic [MODS_W-1:0]                 mods;
    logic [LEN_W-1:0]                  report_len;
  } key_report_t;

  // One key event as it should leave the block
  typedef struct {
    logic [USAGE_W-1:0] usage;
    logic [MODS_W-1:0]  mods;
    logic               is_press;
    logic               last_event;
  } key_event_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // Reports still to send, and key events still owed by the block
  key_report_t report_q[$];
  key_event_t  key_event_q[$];

  // Our own copy of what the block holds from the last accepted report
  logic [USAGE_W-1:0] held_slots [KEY_SLOTS_DEF];
  logic [MODS_W-1:0]  held_mods;

  int fail_count    = 0;
  int reports_taken = 0;
  int short_dropped = 0;
  int presses_seen  = 0;
  int releases_seen = 0;
  int max_per_report = 0;

  bit beat_taken = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;
  int rx_mode    = 0;
  int rx_stretch = 0;
  int rx_hold    = 0;

  keyboard_report_key_diff_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the key events one accepted report causes and advance the held
  // state. Releases first (old keys missing now, old modifiers), then presses
  // (new keys missing before, new modifiers); each in slot order.
  function automatic void diff_report(input key_report_t r);
    key_event_t ev [$];
    key_event_t e;
    bit         found;
    logic [USAGE_W-1:0] u;
    if (r.report_len < MIN_REPORT_BYTES) begin
      short_dropped++;
      return;
    end
    for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
      u = held_slots[i];
      found = 1'b0;
      for (int j = 0; j < IN_SLOTS; j++)
        if (r.slots[j] == u) found = 1'b1;
      if (u > USAGE_RESERVED_MAX && !found) begin
        e = '{usage: u, mods: held_mods, is_press: 1'b0, last_event: 1'b0};
        ev.push_back(e);
      end
    end
    for (int i = 0; i < IN_SLOTS; i++) begin
      u = r.slots[i];
      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS_DEF; j++)
        if (held_slots[j] == u) found = 1'b1;
      if (u > USAGE_RESERVED_MAX && !found) begin
        e = '{usage: u, mods: r.mods, is_press: 1'b1, last_event: 1'b0};
        ev.push_back(e);
      end
    end
    if (ev.size() > 0) ev[ev.size()-1].last_event = 1'b1;
    if (ev.size() > max_per_report) max_per_report = ev.size();
    foreach (ev[k]) key_event_q.push_back(ev[k]);
    for (int i = 0; i < KEY_SLOTS_DEF; i++) held_slots[i] = r.slots[i];
    held_mods = r.mods;
  endfunction

  function automatic key_report_t make_report(
    input int unsigned len, input int unsigned mods,
    input int unsigned s0, input int unsigned s1, input int unsigned s2,
    input int unsigned s3, input int unsigned s4, input int unsigned s5);
    key_report_t r;
    r.pad        = 1'b0;
    r.report_len = len[LEN_W-1:0];
    r.mods       = mods[MODS_W-1:0];
    r.slots[0]   = s0[USAGE_W-1:0];
    r.slots[1]   = s1[USAGE_W-1:0];
    r.slots[2]   = s2[USAGE_W-1:0];
    r.slots[3]   = s3[USAGE_W-1:0];
    r.slots[4]   = s4[USAGE_W-1:0];
    r.slots[5]   = s5[USAGE_W-1:0];
    return r;
  endfunction

  // Rising edge: note an accepted report and predict its events; check any
  // event beat against the oldest prediction.
  always @(posedge clk) begin
    beat_taken = rst_n && in_tvalid && in_tready;
    if (beat_taken) begin
      reports_taken++;
      diff_report(report_q.pop_front());
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (key_event_q.size() == 0) begin
        $error("unexpected key event beat: usage %0d mods 0x%02h press %0b last %0b",
               out_tdata[7:0], out_tdata[15:8], out_tuser, out_tlast);
        fail_count++;
      end else begin
        key_event_t want;
        want = key_event_q.pop_front();
        if (out_tdata[7:0] !== want.usage) begin
          $error("key_usage: expected %0d, got %0d", want.usage, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[15:8] !== want.mods) begin
          $error("event_modifiers: expected 0x%02h, got 0x%02h", want.mods, out_tdata[15:8]);
          fail_count++;
        end
        if (out_tuser !== want.is_press) begin
          $error("is_press: expected %0b, got %0b", want.is_press, out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.last_event) begin
          $error("last_event: expected %0b, got %0b", want.last_event, out_tlast);
          fail_count++;
        end
        if (want.is_press) presses_seen++;
        else releases_seen++;
      end
    end
  end

  // Falling edge, sender: hold a beat until it is taken, otherwise send the
  // next report in bursts of random length, with random gaps between bursts.
  // About a third of bursts run straight into the next one with no gap.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (report_q.size() > 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        in_tdata  <= report_q[0];
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 8);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Falling edge, receiver: stretches of always-ready, coin-toss stalls, a
  // fixed one-in-four stall and occasional long stalls of random length.
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_stretch == 0) begin
        rx_mode    = $urandom_range(0, 3);
        rx_stretch = $urandom_range(20, 200);
      end
      rx_stretch--;
      case (rx_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_tready <= (rx_stretch % 4 != 3);
        end
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 11);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [USAGE_W-1:0] typed [IN_SLOTS];
    logic [MODS_W-1:0]  typed_mods;
    key_report_t        r;
    int unsigned        pick;
    int unsigned        edits;
    int                 counted;

    for (int i = 0; i < KEY_SLOTS_DEF; i++) held_slots[i] = '0;
    held_mods = '0;

    // Directed opening: extremes of every field and each corner of the diff
    // Empty full-size report against cleared state: nothing to report
    report_q.push_back(make_report(8, 8'h00, 0, 0, 0, 0, 0, 0));
    // Single press with one modifier
    report_q.push_back(make_report(8, 8'h02, 4, 0, 0, 0, 0, 0));
    // Short reports must be dropped without touching the held keys
    report_q.push_back(make_report(7, 8'hFF, 255, 255, 255, 255, 255, 255));
    report_q.push_back(make_report(0, 8'h00, 0, 0, 0, 0, 0, 0));
    // Same keys, only the modifiers change: silent, but the modifiers move on
    report_q.push_back(make_report(9, 8'h22, 4, 0, 0, 0, 0, 0));
    // Full slots, largest usage codes and a length above the minimum
    report_q.push_back(make_report(64, 8'hFF, 4, 255, 128, 127, 64, 5));
    // Everything released, tagged with the old modifiers
    report_q.push_back(make_report(127, 8'h00, 0, 0, 0, 0, 0, 0));
    // Reserved usages are stored but never raise an event
    report_q.push_back(make_report(8, 8'h01, 1, 2, 3, 0, 3, 1));
    report_q.push_back(make_report(8, 8'h80, 4, 5, 6, 7, 8, 9));
    // Every slot swapped at once: six releases, then six presses
    report_q.push_back(make_report(8, 8'h55, 10, 11, 12, 13, 14, 15));
    // Duplicate usages give one event per slot
    report_q.push_back(make_report(8, 8'hAA, 20, 20, 20, 21, 21, 0));
    report_q.push_back(make_report(100, 8'h0F, 0, 0, 0, 0, 0, 21));
    // Alternating bit patterns in every slot
    report_q.push_back(make_report(8, 8'hF0, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    report_q.push_back(make_report(65, 8'h5A, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    // Short report between two real ones, then an exact repeat
    report_q.push_back(make_report(1, 8'h00, 9, 9, 9, 9, 9, 9));
    report_q.push_back(make_report(8, 8'h5A, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    report_q.push_back(make_report(8, 8'h00, 0, 0, 0, 0, 0, 0));

    // Random part: mostly typing-like sequences that add and drop a few keys
    // from a small pool (so keys overlap between reports), with some noise,
    // repeats and short reports mixed in.
    for (int i = 0; i < IN_SLOTS; i++) typed[i] = '0;
    typed_mods = '0;
    counted = 0;
    while (counted < 240) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        r = make_report($urandom_range(0, 7), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        if (pick < 20) begin
          for (int i = 0; i < IN_SLOTS; i++) typed[i] = USAGE_W'($urandom_range(0, 255));
          typed_mods = MODS_W'($urandom_range(0, 255));
        end else if (pick < 30) begin
          if ($urandom_range(0, 1) == 0) typed_mods = MODS_W'($urandom_range(0, 255));
        end else begin
          edits = $urandom_range(1, 3);
          for (int k = 0; k < edits; k++) begin
            int unsigned s;
            int unsigned roll;
            s    = $urandom_range(0, IN_SLOTS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 35) typed[s] = '0;
            else if (roll < 75) typed[s] = USAGE_W'($urandom_range(4, 12));
            else if (roll < 90) typed[s] = USAGE_W'($urandom_range(0, 255));
            else typed[s] = USAGE_W'($urandom_range(0, 3));
          end
          if ($urandom_range(0, 9) < 3) typed_mods = MODS_W'($urandom_range(0, 255));
        end
        r = make_report(($urandom_range(0, 9) < 7) ? 8 : $urandom_range(9, 127), typed_mods,
                        typed[0], typed[1], typed[2], typed[3], typed[4], typed[5]);
        counted++;
      end
      report_q.push_back(r);
    end

    // Reset: held from time zero, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every report taken, every event seen, then allow for a late spurious beat.
    while (report_q.size() != 0) @(posedge clk);
    while (key_event_q.size() != 0) @(posedge clk);
    repeat (2 * KEY_SLOTS_DEF + 8) @(posedge clk);

    $display("Covered %0d reports (%0d short ones dropped), up to %0d events per report.",
             reports_taken, short_dropped, max_per_report);
    $display("Checked %0d key presses and %0d key releases under random stalls.",
             presses_seen, releases_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a millisecond
  initial begin : watchdog
    #4000000;
    $display("Timeout: %0d reports pending, %0d events outstanding",
             report_q.size(), key_event_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
